// ===== rtl/pmr_pkg.sv =====
// Shared constants and types for the minimal-standard random generator with a
// bounded draw. No dependencies; every other file in rtl/ uses this package.
package pmr_pkg;

    // Field and state widths
    localparam int STATE_W        = 32;
    localparam int RAW_W          = 31;
    localparam int FIELD_W        = 16;
    localparam int HALF_W         = 16;
    localparam int MULT_W         = 15;
    localparam int RANGE_WIDTH_DEF = 16;

    // Generator constants: multiplier 7^5 and modulus 2^31-1
    localparam logic [MULT_W-1:0] PM_MULT = 15'd16807;
    localparam logic [RAW_W-1:0]  PM_MOD  = 31'h7FFF_FFFF;

    // Operations of the shared multiply/add unit
    typedef enum logic [2:0] {
        LCG_HOLD,
        LCG_LOAD,
        LCG_INC,
        LCG_MUL_LO,
        LCG_MUL_HI,
        LCG_ADD_HI,
        LCG_ADD_CARRY,
        LCG_FOLD
    } lcg_op_t;

    // Control of the remainder unit
    typedef struct packed {
        logic start;
    } mod_ctrl_t;

    typedef struct packed {
        logic last_step;
    } mod_stat_t;

    // Sequencer states of the top level
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD_HI,
        ST_FOLD_HI,
        ST_ADD_CARRY,
        ST_FOLD_CARRY,
        ST_DIV_GO,
        ST_DIV,
        ST_WB
    } pmr_state_t;

endpackage

// ===== rtl/pmr_req_if.sv =====
// Request channel: valid/ready handshake carrying the range of one draw.
// Depends on pmr_pkg for the field width.
interface pmr_req_if;
    logic                        valid;
    logic                        ready;
    logic [pmr_pkg::FIELD_W-1:0] range_limit;

    modport source (output valid, output range_limit, input ready);
    modport sink   (input valid, input range_limit, output ready);
endinterface

// ===== rtl/pmr_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one draw's results.
// Depends on pmr_pkg for the field widths.
interface pmr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pmr_pkg::FIELD_W-1:0] bounded_number;
    logic [pmr_pkg::RAW_W-1:0]   raw_value;
    logic                        range_error;

    modport source (output valid, output bounded_number, output raw_value,
                    output range_error, input ready);
    modport sink   (input valid, input bounded_number, input raw_value,
                    input range_error, output ready);
endinterface

// ===== rtl/pmr_cfg_if.sv =====
// Configuration write channel: valid/ready handshake carrying the seed.
// Depends on pmr_pkg for the register width.
interface pmr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pmr_pkg::STATE_W-1:0] seed_value;

    modport source (output valid, output seed_value, input ready);
    modport sink   (input valid, input seed_value, output ready);
endinterface

// ===== rtl/pmr_lcg_unit.sv =====
// Generator state and the shared 16x15 multiplier / 32-bit adder that advance it.
// Depends on pmr_pkg for constants and the operation codes.
module pmr_lcg_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pmr_pkg::lcg_op_t            op,
    input  logic [pmr_pkg::STATE_W-1:0] seed,
    output logic [pmr_pkg::STATE_W-1:0] value
);

    logic [pmr_pkg::STATE_W-1:0] state_reg, state_next;
    logic [pmr_pkg::STATE_W-1:0] x_reg, x_next;
    logic [pmr_pkg::STATE_W-1:0] acc_reg, acc_next;
    logic [pmr_pkg::RAW_W-1:0]   hi_reg, hi_next;

    logic [pmr_pkg::HALF_W-1:0]  mul_a;
    logic [pmr_pkg::RAW_W-1:0]   prod;
    logic [pmr_pkg::STATE_W-1:0] add_a;
    logic [pmr_pkg::STATE_W-1:0] add_b;
    logic [pmr_pkg::STATE_W-1:0] sum;

    // Shared multiplier: one half of the incremented value per step
    assign mul_a = (op == pmr_pkg::LCG_MUL_HI) ? x_reg[31:16] : x_reg[15:0];
    assign prod  = {15'b0, mul_a} * {16'b0, pmr_pkg::PM_MULT};

    // Shared adder operand select
    always_comb
    begin
        unique case (op)
            pmr_pkg::LCG_INC:
            begin
                add_a = state_reg;
                add_b = 32'd1;
            end
            pmr_pkg::LCG_ADD_HI:
            begin
                add_a = acc_reg;
                add_b = {1'b0, hi_reg[14:0], 16'b0};
            end
            pmr_pkg::LCG_ADD_CARRY:
            begin
                add_a = acc_reg;
                add_b = {16'b0, hi_reg[30:15]};
            end
            pmr_pkg::LCG_FOLD:
            begin
                add_a = {1'b0, acc_reg[30:0]};
                add_b = 32'd1;
            end
            default:
            begin
                add_a = acc_reg;
                add_b = '0;
            end
        endcase
    end

    assign sum = add_a + add_b;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        hi_next    = hi_reg;
        unique case (op)
            pmr_pkg::LCG_HOLD:      ;
            pmr_pkg::LCG_LOAD:      state_next = seed;
            pmr_pkg::LCG_INC:       x_next     = sum;
            pmr_pkg::LCG_MUL_LO:    acc_next   = {1'b0, prod};
            pmr_pkg::LCG_MUL_HI:    hi_next    = prod;
            pmr_pkg::LCG_ADD_HI:    acc_next   = sum;
            pmr_pkg::LCG_ADD_CARRY: acc_next   = sum;
            pmr_pkg::LCG_FOLD:
            begin
                // Fold only above 2^31-1, i.e. when bit 31 is set.
                // The state takes every fold; the second one is final.
                acc_next   = acc_reg[31] ? sum : acc_reg;
                state_next = acc_next;
            end
            default:                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
        hi_reg  <= hi_next;
    end

    assign value = state_reg;

endmodule

// ===== rtl/pmr_mod_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle.
// Depends on pmr_pkg for widths and the control structs.
module pmr_mod_unit #(
    parameter int RANGE_WIDTH = pmr_pkg::RANGE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pmr_pkg::mod_ctrl_t          ctrl,
    input  logic [RANGE_WIDTH-1:0]      dividend,
    input  logic [pmr_pkg::FIELD_W-1:0] divisor,
    output pmr_pkg::mod_stat_t          stat,
    output logic [pmr_pkg::FIELD_W-1:0] remainder
);

    localparam int CNT_W = $clog2(RANGE_WIDTH + 1);

    logic                        busy_reg, busy_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [RANGE_WIDTH-1:0]      dvd_reg, dvd_next;
    logic [pmr_pkg::FIELD_W:0]   rem_reg, rem_next;

    logic [pmr_pkg::FIELD_W:0]   shifted;
    logic [pmr_pkg::FIELD_W:0]   diff;

    assign shifted = {rem_reg[pmr_pkg::FIELD_W-1:0], dvd_reg[RANGE_WIDTH-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RANGE_WIDTH);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // Subtract when the partial remainder reaches the divisor
            rem_next = (shifted >= {1'b0, divisor}) ? diff : shifted;
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign stat.last_step = busy_reg && (cnt_reg == CNT_W'(1));
    assign remainder      = rem_reg[pmr_pkg::FIELD_W-1:0];

endmodule

// ===== rtl/park_miller_random_with_range.sv =====
// Top level of the minimal-standard random generator with a bounded draw.
// Depends on pmr_pkg, the three channel interfaces, pmr_lcg_unit and pmr_mod_unit.
//
// Usage:
//   cfg  - write the 32-bit seed; it loads the generator state. Taken only
//          while the block is idle (cfg.ready high).
//   req  - one request per draw, carrying range_limit. Each request adds one
//          to the state, multiplies by 16807 modulo 2^31-1 and stores it.
//   rsp  - one result per request: raw_value (new state), bounded_number
//          (low RANGE_WIDTH bits of the state modulo the range) and
//          range_error (range of zero; bounded_number is then 0).
// Timing: a request goes through one increment at acceptance, two shared
//   multiplier steps, four add/fold steps on the shared adder, a divider
//   start, one remainder step per dividend bit, then write-back; after that
//   the result and the next request can both be taken. req.ready is high
//   only in the idle state, so one request is in flight at a time.
// Stall: the result sits in an output register; the next request is taken
//   while it waits. If a new result is finished before the old one is taken,
//   hold it in write-back until rsp.ready frees the register.
// Reset: state clears to zero, no result is pending, the block comes up idle.
module park_miller_random_with_range #(
    parameter int RANGE_WIDTH = pmr_pkg::RANGE_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    pmr_cfg_if.sink   cfg,
    pmr_req_if.sink   req,
    pmr_rsp_if.source rsp
);

    // Only the range bits below RANGE_WIDTH take part in the draw
    localparam int RW_CLIP = (RANGE_WIDTH < pmr_pkg::FIELD_W) ? RANGE_WIDTH : pmr_pkg::FIELD_W;
    localparam logic [pmr_pkg::FIELD_W-1:0] RANGE_MASK =
        pmr_pkg::FIELD_W'((33'd1 << RW_CLIP) - 33'd1);

    pmr_pkg::pmr_state_t state_reg, state_next;

    logic [pmr_pkg::FIELD_W-1:0] range_reg, range_next;
    logic                        out_valid_reg, out_valid_next;
    logic [pmr_pkg::FIELD_W-1:0] out_bounded_reg, out_bounded_next;
    logic [pmr_pkg::RAW_W-1:0]   out_raw_reg, out_raw_next;
    logic                        out_err_reg, out_err_next;

    pmr_pkg::lcg_op_t            lcg_op;
    logic [pmr_pkg::STATE_W-1:0] gen_value;
    pmr_pkg::mod_ctrl_t          mod_ctrl;
    pmr_pkg::mod_stat_t          mod_stat;
    logic [pmr_pkg::FIELD_W-1:0] mod_rem;

    logic req_fire;
    logic out_free;

    assign cfg.ready = (state_reg == pmr_pkg::ST_IDLE);
    assign req.ready = (state_reg == pmr_pkg::ST_IDLE) && !cfg.valid;
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    pmr_lcg_unit u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (lcg_op),
        .seed  (cfg.seed_value),
        .value (gen_value)
    );

    pmr_mod_unit #(
        .RANGE_WIDTH (RANGE_WIDTH)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mod_ctrl),
        .dividend  (gen_value[RANGE_WIDTH-1:0]),
        .divisor   (range_reg),
        .stat      (mod_stat),
        .remainder (mod_rem)
    );

    // Sequencer: next state, unit controls and output register loads
    always_comb
    begin
        state_next       = state_reg;
        range_next       = range_reg;
        lcg_op           = pmr_pkg::LCG_HOLD;
        mod_ctrl.start   = 1'b0;
        out_bounded_next = out_bounded_reg;
        out_raw_next     = out_raw_reg;
        out_err_next     = out_err_reg;
        // Drop the pending result once the receiver takes it
        out_valid_next   = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            pmr_pkg::ST_IDLE:
            begin
                if (cfg.valid)
                begin
                    lcg_op = pmr_pkg::LCG_LOAD;
                end
                else if (req_fire)
                begin
                    // Latch the masked range and take the state plus one into the work register
                    range_next = req.range_limit & RANGE_MASK;
                    lcg_op     = pmr_pkg::LCG_INC;
                    state_next = pmr_pkg::ST_MUL_LO;
                end
            end
            pmr_pkg::ST_MUL_LO:
            begin
                lcg_op     = pmr_pkg::LCG_MUL_LO;
                state_next = pmr_pkg::ST_MUL_HI;
            end
            pmr_pkg::ST_MUL_HI:
            begin
                lcg_op     = pmr_pkg::LCG_MUL_HI;
                state_next = pmr_pkg::ST_ADD_HI;
            end
            pmr_pkg::ST_ADD_HI:
            begin
                lcg_op     = pmr_pkg::LCG_ADD_HI;
                state_next = pmr_pkg::ST_FOLD_HI;
            end
            pmr_pkg::ST_FOLD_HI:
            begin
                lcg_op     = pmr_pkg::LCG_FOLD;
                state_next = pmr_pkg::ST_ADD_CARRY;
            end
            pmr_pkg::ST_ADD_CARRY:
            begin
                lcg_op     = pmr_pkg::LCG_ADD_CARRY;
                state_next = pmr_pkg::ST_FOLD_CARRY;
            end
            pmr_pkg::ST_FOLD_CARRY:
            begin
                lcg_op     = pmr_pkg::LCG_FOLD;
                state_next = pmr_pkg::ST_DIV_GO;
            end
            pmr_pkg::ST_DIV_GO:
            begin
                // New state is stored now; start the remainder on its low bits
                mod_ctrl.start = 1'b1;
                state_next     = pmr_pkg::ST_DIV;
            end
            pmr_pkg::ST_DIV:
            begin
                if (mod_stat.last_step)
                begin
                    state_next = pmr_pkg::ST_WB;
                end
            end
            pmr_pkg::ST_WB:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_err_next     = (range_reg == '0);
                    out_bounded_next = (range_reg == '0) ? '0 : mod_rem;
                    out_raw_next     = gen_value[pmr_pkg::RAW_W-1:0];
                    state_next       = pmr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pmr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pmr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg       <= range_next;
        out_bounded_reg <= out_bounded_next;
        out_raw_reg     <= out_raw_next;
        out_err_reg     <= out_err_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.bounded_number = out_bounded_reg;
    assign rsp.raw_value      = out_raw_reg;
    assign rsp.range_error    = out_err_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for park_miller_random_with_range: seeded draws checked
// against a local predictor of the minimal-standard generator and bounded remainder.
// Depends on pmr_pkg, the three channel interfaces and the block itself.
module tb;

    // Generator constants for the predictor: multiplier 7^5, modulus 2^31-1
    localparam logic [31:0] LCG_MULT = 32'd16807;
    localparam logic [31:0] LCG_MOD  = 32'h7FFF_FFFF;
    // Run limit, several times the slowest correct run
    localparam int RUN_LIMIT_NS = 5_000_000;
    // Cycles to wait after the last result, past the block's draw latency
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [pmr_pkg::FIELD_W-1:0] bounded;
        logic [pmr_pkg::RAW_W-1:0]   raw;
        logic                        err;
    } draw_result_t;

    logic clk;
    logic rst_n;

    pmr_cfg_if cfg_ch ();
    pmr_req_if req_ch ();
    pmr_rsp_if rsp_ch ();

    park_miller_random_with_range i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predictor state: the generator value as the block should hold it
    logic [31:0]  gen_state;
    // Draw results still owed by the block, oldest first
    draw_result_t expected_draws[$];
    int           mismatch_count;

    // Traffic shaping knobs, changed by the test tasks
    bit req_gaps_on;
    bit rsp_stalls_on;
    int rsp_hold_cycles;
    bit req_live;

    // Advance the generator one step: increment, split multiply, two folds
    function automatic logic [31:0] lcg_advance(input logic [31:0] cur);
        logic [31:0] x;
        logic [31:0] lo;
        logic [31:0] hi;
        x  = cur + 32'd1;
        lo = LCG_MULT * {16'd0, x[15:0]};
        hi = LCG_MULT * {16'd0, x[31:16]};
        lo = lo + {1'b0, hi[14:0], 16'd0};
        // Fold only when strictly above the modulus, so 2^31-1 itself survives
        if (lo > LCG_MOD)
        begin
            lo = (lo & LCG_MOD) + 32'd1;
        end
        lo = lo + (hi >> 15);
        if (lo > LCG_MOD)
        begin
            lo = (lo & LCG_MOD) + 32'd1;
        end
        return lo;
    endfunction

    // Step the predictor for one accepted request and return what it owes
    function automatic draw_result_t predict_draw(input logic [15:0] range_val);
        draw_result_t res;
        gen_state = lcg_advance(gen_state);
        res.raw   = gen_state[30:0];
        if (range_val == 16'd0)
        begin
            res.err     = 1'b1;
            res.bounded = '0;
        end
        else
        begin
            res.err     = 1'b0;
            res.bounded = gen_state[15:0] % range_val;
        end
        return res;
    endfunction

    // Bias ranges toward the interesting ones: zero, full, tiny, powers of two
    function automatic logic [15:0] random_range_limit();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return 16'd0;
        else if (pick == 1)
            return 16'hFFFF;
        else if (pick <= 3)
            return 16'($urandom_range(1, 16));
        else if (pick == 4)
            return 16'd1 << $urandom_range(0, 15);
        else
            return 16'($urandom());
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Response side: accept results, with short random stalls and an
    // optional long hold-off counted here cycle by cycle
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rsp_stalls_on && $urandom_range(0, 4) == 0)
            begin
                // Start a stalled burst: this cycle, then stall_left more
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        draw_result_t exp_res;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_draws.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got raw_value %h",
                         $time, rsp_ch.raw_value);
                mismatch_count++;
            end
            else
            begin
                exp_res = expected_draws.pop_front();
                if (rsp_ch.raw_value !== exp_res.raw)
                begin
                    $display("%0t: raw_value mismatch: expected %h, got %h",
                             $time, exp_res.raw, rsp_ch.raw_value);
                    mismatch_count++;
                end
                if (rsp_ch.bounded_number !== exp_res.bounded)
                begin
                    $display("%0t: bounded_number mismatch: expected %0d, got %0d",
                             $time, exp_res.bounded, rsp_ch.bounded_number);
                    mismatch_count++;
                end
                if (rsp_ch.range_error !== exp_res.err)
                begin
                    $display("%0t: range_error mismatch: expected %b, got %b",
                             $time, exp_res.err, rsp_ch.range_error);
                    mismatch_count++;
                end
            end
        end
    end

    // Offer one request; return right after the edge that accepts it, with
    // valid still high so a back-to-back request keeps it up
    task automatic send_draw(input logic [15:0] range_val);
        int gap;
        gap = (req_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.range_limit <= range_val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_draws.push_back(predict_draw(range_val));
        req_live = 1'b1;
    endtask

    // Drop valid before any wait that spans clock edges
    task automatic stop_requests();
        if (req_live)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            req_live = 1'b0;
        end
    endtask

    // Hold the request side until every owed result has come back
    task automatic wait_drained();
        stop_requests();
        while (expected_draws.size() != 0)
            @(posedge clk);
    endtask

    // Load a new seed once the block is idle; the predictor follows
    task automatic write_seed(input logic [31:0] seed);
        wait_drained();
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.seed_value <= seed;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        gen_state = seed;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Draws straight out of reset, state zero: unit, zero and full range, 2^15, two
    task automatic test_reset_draws();
        send_draw(16'd1);
        send_draw(16'd0);
        send_draw(16'hFFFF);
        send_draw(16'h8000);
        send_draw(16'd2);
    endtask

    // Seed corners: all ones wraps to zero on increment, seeds that land on
    // a multiple of the modulus (result kept unfolded at 2^31-1), top bit set, zero
    task automatic test_seed_corners();
        write_seed(32'hFFFF_FFFF);
        send_draw(16'd3);
        send_draw(16'd0);
        send_draw(16'hFFFF);
        write_seed(32'h7FFF_FFFE);
        send_draw(16'd1);
        send_draw(16'h7FFF);
        send_draw(16'hAAAA);
        write_seed(32'hFFFF_FFFD);
        send_draw(16'h5555);
        send_draw(16'd0);
        write_seed(32'h8000_0000);
        send_draw(16'hFFFE);
        send_draw(16'd7);
        write_seed(32'hFFFF_FFFE);
        send_draw(16'h0100);
        send_draw(16'd0);
        write_seed(32'h0000_0000);
        send_draw(16'hFFFF);
        send_draw(16'd1);
        send_draw(16'd16);
        send_draw(16'd0);
    endtask

    // Random draws over several seeds, idling switched on and off in stretches
    task automatic test_random_phases();
        logic [31:0] seed;
        for (int phase = 0; phase < 5; phase++)
        begin
            seed = $urandom();
            if (phase == 1)
                seed[31] = 1'b1;
            else if (phase == 2)
                seed[31] = 1'b0;
            write_seed(seed);
            for (int n = 0; n < 280; n++)
            begin
                if (n % 40 == 0)
                begin
                    req_gaps_on   = ($urandom_range(0, 2) != 0);
                    rsp_stalls_on = ($urandom_range(0, 2) != 0);
                end
                send_draw(random_range_limit());
            end
        end
    endtask

    // Hold off the response side long enough that the output register and
    // write-back fill and the block stops taking requests, then pause the
    // sender until everything owed has come back
    task automatic test_backpressure();
        req_gaps_on     = 1'b0;
        rsp_stalls_on   = 1'b0;
        wait_drained();
        rsp_hold_cycles = 300;
        for (int n = 0; n < 12; n++)
            send_draw(random_range_limit());
        wait_drained();
    endtask

    // Closing stretch at full rate, no idling on either side
    task automatic test_streaming();
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        write_seed($urandom());
        for (int n = 0; n < 260; n++)
            send_draw(random_range_limit());
    endtask

    // Main sequence
    initial
    begin
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.seed_value  = '0;
        req_ch.valid       = 1'b0;
        req_ch.range_limit = '0;
        gen_state          = '0;
        mismatch_count     = 0;
        req_gaps_on        = 1'b1;
        rsp_stalls_on      = 1'b1;
        rsp_hold_cycles    = 0;
        req_live           = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_draws();
        test_seed_corners();
        test_random_phases();
        test_backpressure();
        test_streaming();

        // Drain, then give any stray result time to show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_draws.size() == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb failed");
        $finish;
    end

endmodule
